### rtl/ordered_list_store_macros.svh
// Assertion macros for the ordered list store checker.
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OLST_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define OLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/olst_pkg.sv
// Shared types and constants for the ordered list store.
package olst_pkg;

  localparam int KEY_W   = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE_HEAD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_TAIL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_MATCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift_all;  // every cell takes its upper neighbor's key
    logic shift_hit;  // cells at or above the first match take the neighbor's key
    logic clr_hit;    // restart the match wave
    logic scan;       // advance the match wave one cell
  } cell_ctrl_t;

endpackage

### rtl/olst_cell.sv
// One storage cell of the list: a key register and one stage of the match wave.
module olst_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  olst_pkg::cell_ctrl_t           ctrl,
  input  logic                           load,
  input  logic [olst_pkg::KEY_W-1:0]     load_key,
  input  logic [olst_pkg::KEY_W-1:0]     nbr_key,
  input  logic [olst_pkg::KEY_W-1:0]     srch_key,
  input  logic                           valid,
  input  logic                           hit_in,
  output logic [olst_pkg::KEY_W-1:0]     key_q,
  output logic                           hit_q
);

  logic [olst_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                       hit_r, hit_nxt;

  always_comb begin
    key_nxt = key_r;
    if (load) begin
      key_nxt = load_key;
    end else if (ctrl.shift_all || (ctrl.shift_hit && hit_r)) begin
      key_nxt = nbr_key;
    end
  end

  // hit: some valid cell at or below this one holds the search key
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.clr_hit) begin
      hit_nxt = 1'b0;
    end else if (ctrl.scan) begin
      hit_nxt = hit_in || (valid && (key_r == srch_key));
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign key_q = key_r;
  assign hit_q = hit_r;

endmodule

### rtl/ordered_list_store.sv
// Ordered list store: a chain of DEPTH key cells under a small command sequencer.
//
// Commands are taken when start is high and busy is low; each gives one result word,
// strobed on out_strobe for one cycle, which the receiver must take as it comes.
// Append, remove head, remove tail, clear, unknown codes and remove first match on an
// empty list are answered directly: the result shows in the cycle after the command and
// busy stays low, so a new command can follow every cycle. Remove first match on a
// non-empty list holds busy high through the S_SCAN and S_FINISH states: a hit
// flag ripples up the cell chain one cell per cycle, and S_FINISH then closes the gap;
// its result shows in the first cycle with busy low again.
module ordered_list_store #(
  parameter int DEPTH = olst_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  olst_pkg::in_word_t  in_item,
  output logic                out_strobe,
  output olst_pkg::out_word_t out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                scan_cnt_r, scan_cnt_nxt;
  logic [olst_pkg::KEY_W-1:0]      srch_key_r, srch_key_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  olst_pkg::out_word_t             out_item_r, out_item_nxt;

  olst_pkg::cell_ctrl_t            ctrl;
  logic                            do_load;
  logic                            accept;
  logic [olst_pkg::STAT_W-1:0]     status;
  logic                            report;
  logic                            is_empty;
  logic                            is_full;

  logic [olst_pkg::KEY_W-1:0]      key_q [DEPTH];
  logic [DEPTH-1:0]                hit_q;
  logic [DEPTH-1:0]                load_vec;
  logic [DEPTH-1:0]                valid_vec;

  assign accept   = start && (state_r == S_IDLE);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r >= CNT_W'(DEPTH));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_cnt_nxt = scan_cnt_r;
    srch_key_nxt = srch_key_r;
    ctrl         = '0;
    do_load      = 1'b0;
    status       = olst_pkg::ST_OK;
    report       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          report = 1'b1;
          case (in_item.cmd)
            olst_pkg::CMD_APPEND: begin
              if (is_full) begin
                status = olst_pkg::ST_FULL;
              end else begin
                do_load   = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            olst_pkg::CMD_REMOVE_HEAD: begin
              if (is_empty) begin
                status = olst_pkg::ST_EMPTY;
              end else begin
                ctrl.shift_all = 1'b1;
                count_nxt      = count_r - 1'b1;
              end
            end
            olst_pkg::CMD_REMOVE_TAIL: begin
              if (is_empty) begin
                status = olst_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            olst_pkg::CMD_REMOVE_MATCH: begin
              if (is_empty) begin
                status = olst_pkg::ST_EMPTY;
              end else begin
                report       = 1'b0;
                ctrl.clr_hit = 1'b1;
                srch_key_nxt = in_item.key;
                scan_cnt_nxt = '0;
                state_nxt    = S_SCAN;
              end
            end
            olst_pkg::CMD_CLEAR: begin
              if (is_empty) begin
                status = olst_pkg::ST_EMPTY;
              end else begin
                count_nxt = '0;
              end
            end
            default: begin
              status = olst_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctrl.scan    = 1'b1;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        report    = 1'b1;
        state_nxt = S_IDLE;
        // top cell's hit says whether any valid cell matched
        if (hit_q[DEPTH-1]) begin
          ctrl.shift_hit = 1'b1;
          count_nxt      = count_r - 1'b1;
        end else begin
          status = olst_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_strobe_nxt           = report;
    out_item_nxt             = out_item_r;
    if (report) begin
      out_item_nxt.status      = status;
      out_item_nxt.entry_count = olst_pkg::COUNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      scan_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srch_key_r <= srch_key_nxt;
    out_item_r <= out_item_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [olst_pkg::KEY_W-1:0] nbr_key;
    logic                       hit_in;

    assign load_vec[i]  = do_load && (count_r == CNT_W'(i));
    assign valid_vec[i] = (CNT_W'(i) < count_r);

    if (i == DEPTH - 1) begin : g_top
      assign nbr_key = key_q[i];
    end else begin : g_mid
      assign nbr_key = key_q[i+1];
    end

    if (i == 0) begin : g_bot
      assign hit_in = 1'b0;
    end else begin : g_up
      assign hit_in = hit_q[i-1];
    end

    olst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .load     (load_vec[i]),
      .load_key (in_item.key),
      .nbr_key  (nbr_key),
      .srch_key (srch_key_r),
      .valid    (valid_vec[i]),
      .hit_in   (hit_in),
      .key_q    (key_q[i]),
      .hit_q    (hit_q[i])
    );
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

### rtl/olst_chk.sv
// Port-level checker for the ordered list store, bound to the top level.
`include "ordered_list_store_macros.svh"

module olst_chk #(
  parameter int DEPTH = olst_pkg::DEPTH_DEFAULT
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input olst_pkg::in_word_t  in_item,
  input logic                out_strobe,
  input olst_pkg::out_word_t out_item
);

  `OLST_ASSERT_NEXT(a_quick_cmd_answers, clk, rst_n, start && !busy && (in_item.cmd != olst_pkg::CMD_REMOVE_MATCH), out_strobe, "single-cycle command gave no result word")

  `OLST_ASSERT(a_full_count, clk, rst_n, out_strobe && (out_item.status == olst_pkg::ST_FULL), out_item.entry_count == olst_pkg::COUNT_W'(DEPTH), "full status with count below depth")

  `OLST_ASSERT(a_empty_count, clk, rst_n, out_strobe && (out_item.status == olst_pkg::ST_EMPTY), out_item.entry_count == '0, "empty status with nonzero count")

  `OLST_ASSERT(a_no_word_at_scan_start, clk, rst_n, $rose(busy), !out_strobe, "result word while a search starts")

endmodule

bind ordered_list_store olst_chk #(.DEPTH(DEPTH)) u_olst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

### sim/tb_top.sv
// Self-checking testbench for the ordered list store: directed table, then random command mix.
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH = olst_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_GAP = 18;
  localparam int STALL_LIMIT = 2000;

  // codes the block treats as no-ops
  localparam logic [olst_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd5;
  localparam logic [olst_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd6;
  localparam logic [olst_pkg::CMD_W-1:0] CMD_UNUSED_C = 3'd7;

  typedef struct {
    olst_pkg::in_word_t  w;
    int                  reps;
    bit                  typed;
    olst_pkg::out_word_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  olst_pkg::in_word_t  in_item;
  logic                out_strobe;
  olst_pkg::out_word_t out_item;

  // typed expectation riding along with the word being offered
  bit                  row_typed;
  olst_pkg::out_word_t row_want;

  plan_row_t           plan[$];
  olst_pkg::out_word_t expected_words[$];
  logic [olst_pkg::KEY_W-1:0] shadow_keys [DEPTH];
  int        shadow_fill = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;

  logic [olst_pkg::KEY_W-1:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                               32'h1234_5678, 32'h8000_0001, 32'h5555_AAAA};

  ordered_list_store #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // Apply one command to the shadow list and return the status/count word it yields.
  function automatic olst_pkg::out_word_t list_apply(input olst_pkg::in_word_t w);
    olst_pkg::out_word_t r;
    int pos;
    r.status = olst_pkg::ST_OK;
    pos = -1;
    case (w.cmd)
      olst_pkg::CMD_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          r.status = olst_pkg::ST_FULL;
        end else begin
          shadow_keys[shadow_fill] = w.key;
          shadow_fill++;
        end
      end
      olst_pkg::CMD_REMOVE_HEAD: begin
        if (shadow_fill == 0) r.status = olst_pkg::ST_EMPTY;
        else pos = 0;
      end
      olst_pkg::CMD_REMOVE_TAIL: begin
        if (shadow_fill == 0) r.status = olst_pkg::ST_EMPTY;
        else shadow_fill--;
      end
      olst_pkg::CMD_REMOVE_MATCH: begin
        if (shadow_fill == 0) begin
          r.status = olst_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            if (pos < 0 && shadow_keys[i] == w.key) pos = i;
          r.status = (pos >= 0) ? olst_pkg::ST_OK : olst_pkg::ST_NOTFOUND;
        end
      end
      olst_pkg::CMD_CLEAR: begin
        if (shadow_fill == 0) r.status = olst_pkg::ST_EMPTY;
        else shadow_fill = 0;
      end
      default: ;
    endcase
    // close the gap left by a head or match removal
    if (pos >= 0) begin
      for (int i = pos; i + 1 < shadow_fill; i++) shadow_keys[i] = shadow_keys[i + 1];
      shadow_fill--;
    end
    r.entry_count = olst_pkg::COUNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_row(input logic [olst_pkg::CMD_W-1:0] cmd,
                         input logic [olst_pkg::KEY_W-1:0] key,
                         input int reps, input bit typed,
                         input logic [olst_pkg::STAT_W-1:0] status, input int count);
    plan_row_t row;
    row.w.cmd = cmd;
    row.w.key = key;
    row.reps = reps;
    row.typed = typed;
    row.want.status = status;
    row.want.entry_count = olst_pkg::COUNT_W'(count);
    plan.push_back(row);
  endtask

  task automatic build_plan();
    add_row(olst_pkg::CMD_REMOVE_HEAD,  32'h0000_0000, 1, 1'b1, olst_pkg::ST_EMPTY, 0);
    add_row(olst_pkg::CMD_REMOVE_TAIL,  32'hFFFF_FFFF, 1, 1'b1, olst_pkg::ST_EMPTY, 0);
    add_row(olst_pkg::CMD_REMOVE_MATCH, 32'h0000_0000, 1, 1'b1, olst_pkg::ST_EMPTY, 0);
    add_row(olst_pkg::CMD_CLEAR,        32'h0000_0000, 1, 1'b1, olst_pkg::ST_EMPTY, 0);
    add_row(CMD_UNUSED_A,               32'h8000_0000, 1, 1'b1, olst_pkg::ST_OK, 0);
    add_row(olst_pkg::CMD_APPEND,       32'h8000_0000, 1, 1'b1, olst_pkg::ST_OK, 1);
    add_row(olst_pkg::CMD_APPEND,       32'h7FFF_FFFF, 1, 1'b1, olst_pkg::ST_OK, 2);
    add_row(olst_pkg::CMD_APPEND,       32'h0000_0000, 1, 1'b1, olst_pkg::ST_OK, 3);
    add_row(olst_pkg::CMD_APPEND,       32'hFFFF_FFFF, 1, 1'b1, olst_pkg::ST_OK, 4);
    add_row(olst_pkg::CMD_APPEND,       32'h7FFF_FFFF, 1, 1'b0, olst_pkg::ST_OK, 0);
    // duplicate key: only the one nearer the head goes
    add_row(olst_pkg::CMD_REMOVE_MATCH, 32'h7FFF_FFFF, 1, 1'b0, olst_pkg::ST_OK, 0);
    add_row(olst_pkg::CMD_REMOVE_MATCH, 32'h0001_2345, 1, 1'b1, olst_pkg::ST_NOTFOUND, 4);
    add_row(CMD_UNUSED_B,               32'hFFFF_FFFF, 1, 1'b1, olst_pkg::ST_OK, 4);
    add_row(olst_pkg::CMD_REMOVE_HEAD,  32'h0000_0000, 1, 1'b0, olst_pkg::ST_OK, 0);
    add_row(olst_pkg::CMD_REMOVE_TAIL,  32'h0000_0000, 1, 1'b0, olst_pkg::ST_OK, 0);
    add_row(olst_pkg::CMD_APPEND,       32'h5A5A_5A5A, DEPTH - 3, 1'b0, olst_pkg::ST_OK, 0);
    add_row(olst_pkg::CMD_APPEND,       32'hA5A5_A5A5, 1, 1'b1, olst_pkg::ST_OK, DEPTH);
    add_row(olst_pkg::CMD_APPEND,       32'h0000_0001, 1, 1'b1, olst_pkg::ST_FULL, DEPTH);
    // match sits in the last slot
    add_row(olst_pkg::CMD_REMOVE_MATCH, 32'hA5A5_A5A5, 1, 1'b1, olst_pkg::ST_OK, DEPTH - 1);
    add_row(CMD_UNUSED_C,               32'h0000_0000, 1, 1'b1, olst_pkg::ST_OK, DEPTH - 1);
    add_row(olst_pkg::CMD_CLEAR,        32'h7FFF_FFFF, 1, 1'b1, olst_pkg::ST_OK, 0);
    add_row(olst_pkg::CMD_REMOVE_MATCH, 32'h5A5A_5A5A, 1, 1'b1, olst_pkg::ST_EMPTY, 0);
  endtask

  function automatic logic [olst_pkg::CMD_W-1:0] pick_cmd(input int tilt);
    int r;
    r = $urandom_range(0, 99);
    if (r < tilt) return olst_pkg::CMD_APPEND;
    r = $urandom_range(0, 99);
    if (r < 15) return olst_pkg::CMD_REMOVE_HEAD;
    if (r < 30) return olst_pkg::CMD_REMOVE_TAIL;
    if (r < 85) return olst_pkg::CMD_REMOVE_MATCH;
    if (r < 92) return olst_pkg::CMD_CLEAR;
    if (r < 95) return CMD_UNUSED_A;
    if (r < 98) return CMD_UNUSED_B;
    return CMD_UNUSED_C;
  endfunction

  // mostly a small pool so that matches and duplicates are common
  function automatic logic [olst_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom();
      default: return key_pool[$urandom_range(0, 5)];
    endcase
  endfunction

  // Offer one word after gap idle cycles; returns at the edge that takes it.
  task automatic issue_word(input olst_pkg::in_word_t w, input int gap, input bit typed,
                            input olst_pkg::out_word_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every expected word has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor
    olst_pkg::out_word_t want;
    bit took;
    took = 1'b0;
    if (rst_n) begin
      if (out_strobe) begin
        took = 1'b1;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word status=%0d count=%0d",
                                    out_item.status, out_item.entry_count));
        end else begin
          want = expected_words.pop_front();
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_item.status, want.status));
          if (out_item.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_item.entry_count, want.entry_count));
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        want = list_apply(in_item);
        if (row_typed) want = row_want;
        expected_words.push_back(want);
      end
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    olst_pkg::in_word_t w;
    int tilt;
    bit burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    row_typed = 1'b0;
    row_want = '0;
    tilt = 50;
    burst = 1'b0;
    build_plan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[n])
      for (int k = 0; k < plan[n].reps; k++)
        issue_word(plan[n].w, $urandom_range(0, MAX_GAP), plan[n].typed, plan[n].want);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: tilt = 85;
          1: tilt = 55;
          default: tilt = 25;
        endcase
        burst = ($urandom_range(0, 3) == 0);
      end
      if (n % 100 == 99) wait_drained();
      w.cmd = pick_cmd(tilt);
      w.key = pick_key();
      issue_word(w, burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
    end

    wait_drained();
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### ordered_list_store.f
+incdir+rtl
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_store.sv
rtl/olst_chk.sv
sim/tb_top.sv
